// ----- hdl/edpsd_pkg.sv -----
// Shared types and constants of the Elias delta prefix-sum decoder.
`default_nettype none

package edpsd_pkg;

   localparam int unsigned WORD_BITS   = 64;
   localparam int unsigned OFFSET_BITS = 6;
   localparam int unsigned VCOUNT_BITS = 32;

   typedef logic [WORD_BITS-1:0]   word_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [VCOUNT_BITS-1:0] vcount_type;
   typedef logic                   func_type;

   // Item kinds on the request channel
   localparam func_type FUNC_START = 1'b0;
   localparam func_type FUNC_WORD  = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/edpsd_if.sv -----
// Request and response channel interfaces of the Elias delta prefix-sum decoder.
`default_nettype none

interface edpsd_req_if;
   import edpsd_pkg::*;

   logic       valid;
   logic       ready;
   func_type   func;
   word_type   stream_word;
   offset_type bit_offset;
   vcount_type value_count;

   modport source (output valid, func, stream_word, bit_offset, value_count, input ready);
   modport sink   (input valid, func, stream_word, bit_offset, value_count, output ready);
endinterface

interface edpsd_rsp_if;
   import edpsd_pkg::*;

   logic     valid;
   logic     ready;
   word_type sum;
   logic     malformed;

   modport source (output valid, sum, malformed, input ready);
   modport sink   (input valid, sum, malformed, output ready);
endinterface

`default_nettype wire

// ----- hdl/elias_delta_prefix_sum_decoder.sv -----
// Elias delta prefix-sum decoder: bit-serial code walker with a registered result.
// Start item: opens a query; a zero count sets its result pending without any word item.
// Word item: one stream bit per cycle through the word shift register until its 64 bits are
//    done or the query ends, the leading bit_offset bits of the first word counted off there.
// Result: held pending, then registered once the output is free; next item while it waits there.
// Reset (synchronous): no query active, no result pending, ready high.
`default_nettype none

module elias_delta_prefix_sum_decoder #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   edpsd_req_if.sink   req_ch,
   edpsd_rsp_if.source rsp_ch
);
   import edpsd_pkg::*;

   // Code phases
   localparam logic [1:0] PH_UNARY  = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_VALUE  = 2'd2;

   localparam logic [2:0] MAX_ZERO_RUN = 3'd6;
   localparam logic [6:0] MAX_LEN      = 7'd64;
   localparam logic [5:0] LAST_BIT     = 6'd63;

   typedef logic [COUNT_BITS-1:0] remain_type;

   // Control state
   logic       active_ff, active_in;
   logic       scan_ff, scan_in;
   logic       emit_pend_ff, emit_pend_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] phase_ff, phase_in;
   logic [2:0] zero_run_ff, zero_run_in;
   logic [6:0] left_ff, left_in;
   logic [5:0] skip_ff, skip_in;
   logic [5:0] cnt_ff, cnt_in;
   remain_type rem_ff, rem_in;

   // Payload state
   word_type word_ff, word_in;
   word_type field_ff, field_in;
   word_type mask_ff, mask_in;
   word_type sum_ff, sum_in;
   logic     bad_ff, bad_in;
   word_type rsp_sum_ff, rsp_sum_in;
   logic     rsp_bad_ff, rsp_bad_in;

   // Per-bit helpers
   logic       ready;
   logic       accept;
   logic       bit_v;
   word_type   field_gather;
   word_type   mask_shift;
   logic [6:0] len_v;
   remain_type rem_load;
   logic       finish;
   logic       bad;
   word_type   addend;

   assign ready  = !scan_ff && !emit_pend_ff;
   assign accept = req_ch.valid && ready;

   assign bit_v        = word_ff[0];
   assign field_gather = field_ff | (bit_v ? mask_ff : '0);
   assign mask_shift   = {mask_ff[WORD_BITS-2:0], 1'b0};
   assign len_v        = (field_gather[6:0] | mask_shift[6:0]) - 7'd1;
   assign rem_load     = COUNT_BITS'(req_ch.value_count);

   // Decode one bit per cycle and sequence items
   always_comb begin
      active_in    = active_ff;
      scan_in      = scan_ff;
      emit_pend_in = emit_pend_ff;
      rsp_valid_in = rsp_valid_ff;
      phase_in     = phase_ff;
      zero_run_in  = zero_run_ff;
      left_in      = left_ff;
      skip_in      = skip_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      word_in      = word_ff;
      field_in     = field_ff;
      mask_in      = mask_ff;
      sum_in       = sum_ff;
      bad_in       = bad_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_bad_in   = rsp_bad_ff;
      finish       = 1'b0;
      bad          = 1'b0;
      addend       = word_type'(1);

      if (accept) begin
         if (req_ch.func == FUNC_START) begin
            // Open a query; a zero count answers at once
            skip_in     = req_ch.bit_offset;
            rem_in      = rem_load;
            sum_in      = '0;
            bad_in      = 1'b0;
            phase_in    = PH_UNARY;
            zero_run_in = '0;
            if (rem_load == '0) begin
               active_in    = 1'b0;
               emit_pend_in = 1'b1;
            end else begin
               active_in = 1'b1;
            end
         end else if (active_ff) begin
            // Load the word and start the bit scan
            word_in = req_ch.stream_word;
            cnt_in  = '0;
            scan_in = 1'b1;
         end
      end else if (scan_ff) begin
         word_in = word_ff >> 1;
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == LAST_BIT) begin
            scan_in = 1'b0;
         end
         if (skip_ff != '0) begin
            skip_in = skip_ff - 6'd1;
         end else begin
            case (phase_ff)
               PH_LENGTH: begin
                  field_in = field_gather;
                  mask_in  = mask_shift;
                  left_in  = left_ff - 7'd1;
                  if (left_ff == 7'd1) begin
                     if (len_v > MAX_LEN) begin
                        bad = 1'b1;
                     end else begin
                        phase_in = PH_VALUE;
                        left_in  = len_v;
                        field_in = '0;
                        mask_in  = word_type'(1);
                     end
                  end
               end
               PH_VALUE: begin
                  field_in = field_gather;
                  mask_in  = mask_shift;
                  left_in  = left_ff - 7'd1;
                  if (left_ff == 7'd1) begin
                     // Leading one sits where the mask ended; gone for a 64-bit value field
                     finish = 1'b1;
                     addend = field_gather | mask_shift;
                  end
               end
               default: begin
                  if (!bit_v) begin
                     if (zero_run_ff == MAX_ZERO_RUN) begin
                        bad = 1'b1;
                     end else begin
                        zero_run_in = zero_run_ff + 3'd1;
                     end
                  end else if (zero_run_ff == '0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_LENGTH;
                     left_in  = {4'b0, zero_run_ff};
                     field_in = '0;
                     mask_in  = word_type'(1);
                  end
               end
            endcase

            // Add a finished code and count it off
            if (finish) begin
               sum_in      = sum_ff + addend;
               rem_in      = rem_ff - remain_type'(1);
               phase_in    = PH_UNARY;
               zero_run_in = '0;
            end

            // End the query: drop the rest of the word, hold the result
            if (bad || (finish && rem_ff == remain_type'(1))) begin
               active_in    = 1'b0;
               scan_in      = 1'b0;
               emit_pend_in = 1'b1;
               bad_in       = bad;
               phase_in     = PH_UNARY;
               zero_run_in  = '0;
            end
         end
      end

      // Move a held result into the output register
      if (emit_pend_ff && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = sum_ff;
         rsp_bad_in   = bad_ff;
         emit_pend_in = 1'b0;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         scan_ff      <= 1'b0;
         emit_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_UNARY;
         zero_run_ff  <= '0;
         left_ff      <= '0;
         skip_ff      <= '0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         scan_ff      <= scan_in;
         emit_pend_ff <= emit_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         zero_run_ff  <= zero_run_in;
         left_ff      <= left_in;
         skip_ff      <= skip_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      field_ff   <= field_in;
      mask_ff    <= mask_in;
      sum_ff     <= sum_in;
      bad_ff     <= bad_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign req_ch.ready     = ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.sum       = rsp_sum_ff;
   assign rsp_ch.malformed = rsp_bad_ff;

endmodule

`default_nettype wire

// ----- hdl/edpsd_checker.sv -----
// Port-level checks of the Elias delta prefix-sum decoder and their binding.
`default_nettype none

module edpsd_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire edpsd_pkg::func_type  req_func,
   input wire edpsd_pkg::vcount_type req_value_count,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire edpsd_pkg::word_type  rsp_sum,
   input wire logic                 rsp_malformed
);
   import edpsd_pkg::*;

   logic zero_start;

   assign zero_start = req_valid && req_ready && (req_func == FUNC_START)
                       && (req_value_count == '0);

   // A result waits until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   // A stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sum) && $stable(rsp_malformed))
      else $error("stalled result changed");

   // A zero-count start holds off the next item while its result is placed
   a_zero_blocks: assert property (@(posedge clock) disable iff (reset)
      zero_start |=> !req_ready)
      else $error("item taken while a zero-count result was pending");

   // A zero-count start with a free output gives a clean zero through the pending flag and the output register
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      zero_start && !rsp_valid |-> ##2 (rsp_valid && (rsp_sum == '0) && !rsp_malformed))
      else $error("zero-count start did not give a zero result");

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind elias_delta_prefix_sum_decoder edpsd_checker u_edpsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_func        (req_ch.func),
   .req_value_count (req_ch.value_count),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_sum         (rsp_ch.sum),
   .rsp_malformed   (rsp_ch.malformed)
);

`default_nettype wire
